// ===== rtl/urr_pkg.sv =====
// ----------------------------------------------------------------------------
// urr_pkg
// Shared constants, types and command/status structs for the ranger.
// ----------------------------------------------------------------------------
package urr_pkg;

  localparam int SENSOR_COUNT = 4;
  localparam int IDX_W        = $clog2(SENSOR_COUNT);

  localparam int ECHO_W   = 4;
  localparam int QUERY_W  = 2;
  localparam int TRIG_W   = 4;
  localparam int ACT_W    = 2;
  localparam int DIST_W   = 12;
  localparam int CNT_W    = 16;
  localparam int TCNT_W   = 4;
  localparam int PERIOD_W = 7;
  localparam int SPEED_W  = 10;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [TCNT_W-1:0]   RST_TRIGGER_TICKS = TCNT_W'(2);
  localparam logic [PERIOD_W-1:0] RST_TICK_PERIOD   = PERIOD_W'(10);
  localparam logic [SPEED_W-1:0]  RST_SOUND_SPEED   = SPEED_W'(340);

  localparam int INTERVAL_W = 16;
  localparam logic [INTERVAL_W-1:0] INTERVAL_MAX = '1;
  localparam int P1_W = CNT_W + PERIOD_W;
  localparam int P2_W = INTERVAL_W + SPEED_W;

  // x / 20000 == (x >> 5) / 625; the latter by reciprocal multiply
  localparam int PRE_SHIFT   = 5;
  localparam int Y_W         = P2_W - PRE_SHIFT;
  localparam int RECIP_W     = 22;
  localparam int RECIP_SHIFT = 31;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(3435974);
  localparam int P3_W = Y_W + RECIP_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRIGGER_TICKS = 2'd0,
    CFG_TICK_PERIOD   = 2'd1,
    CFG_SOUND_SPEED   = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_TRIGGER = 2'd0,
    PH_ECHO    = 2'd1,
    PH_DONE    = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_STEP,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_FINISH
  } ctl_state_t;

  typedef struct packed {
    logic idle;
    logic step;
    logic mul1;
    logic mul2;
    logic mul3;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic accepted;
    logic measure;
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/urr_if.sv =====
// ----------------------------------------------------------------------------
// urr_if
// Valid/ready channels for tick items and result items.
// ----------------------------------------------------------------------------
interface urr_in_if
  import urr_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [ECHO_W-1:0]  echo_levels;
  logic [QUERY_W-1:0] query_sensor;

  modport source (output valid, echo_levels, query_sensor, input ready);
  modport sink   (input valid, echo_levels, query_sensor, output ready);
endinterface

interface urr_out_if
  import urr_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [TRIG_W-1:0] trigger_levels;
  logic [ACT_W-1:0]  active_sensor;
  logic              measure_done;
  logic [ACT_W-1:0]  done_sensor;
  logic [DIST_W-1:0] done_distance;
  logic [DIST_W-1:0] queried_distance;

  modport source (output valid, trigger_levels, active_sensor, measure_done,
                  done_sensor, done_distance, queried_distance, input ready);
  modport sink   (input valid, trigger_levels, active_sensor, measure_done,
                  done_sensor, done_distance, queried_distance, output ready);
endinterface

// ===== rtl/urr_ctrl.sv =====
// ----------------------------------------------------------------------------
// urr_ctrl
// Sequencer: accept, tick step, three multiply stages on a completing tick, result handoff.
// ----------------------------------------------------------------------------
module urr_ctrl
  import urr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        cmd.idle = 1'b1;
        if (status.accepted) state_next = S_STEP;
      end
      S_STEP: begin
        cmd.step   = 1'b1;
        state_next = status.measure ? S_MUL1 : S_FINISH;
      end
      S_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = S_MUL3;
      end
      S_MUL3: begin
        cmd.mul3   = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        if (status.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/urr_dpath.sv =====
// ----------------------------------------------------------------------------
// urr_dpath
// Sensor state, tick update, distance multiplier chain, store and result reg.
// ----------------------------------------------------------------------------
module urr_dpath
  import urr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  urr_in_if.sink                tick,
  urr_out_if.source             result,
  input  dp_cmd_t               cmd,
  output dp_status_t            status
);

  logic [TCNT_W-1:0]   trig_ticks;
  logic [PERIOD_W-1:0] period;
  logic [SPEED_W-1:0]  speed;

  always_ff @(posedge clk) begin
    if (rst) begin
      trig_ticks <= RST_TRIGGER_TICKS;
      period     <= RST_TICK_PERIOD;
      speed      <= RST_SOUND_SPEED;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_TRIGGER_TICKS: trig_ticks <= cfg_data[TCNT_W-1:0];
        CFG_TICK_PERIOD:   period     <= cfg_data[PERIOD_W-1:0];
        CFG_SOUND_SPEED:   speed      <= cfg_data[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  logic                accepted;
  logic [ECHO_W-1:0]   echo_lat;
  logic [QUERY_W-1:0]  query_lat;

  assign tick.ready = cmd.idle;
  assign accepted   = tick.valid && tick.ready;

  always_ff @(posedge clk) begin
    if (accepted) begin
      echo_lat  <= tick.echo_levels;
      query_lat <= tick.query_sensor;
    end
  end

  logic [IDX_W-1:0]  cur_idx, cur_idx_next;
  phase_t            phase, phase_next;
  logic [TCNT_W-1:0] tcount, tcount_next;
  logic              seen, seen_next;
  logic [CNT_W-1:0]  ecount, ecount_next;
  logic [TRIG_W-1:0] tout, tout_next;
  logic              step_done;
  logic [CNT_W-1:0]  step_cnt;
  logic              level;

  always_comb begin
    cur_idx_next = cur_idx;
    phase_next   = phase;
    tcount_next  = tcount;
    seen_next    = seen;
    ecount_next  = ecount;
    tout_next    = tout;
    step_done    = 1'b0;
    step_cnt     = ecount;
    level        = 1'b0;

    if (phase == PH_TRIGGER) begin
      for (int i = 0; i < TRIG_W; i++) begin
        tout_next[i] = (32'(cur_idx) == i);
      end
      tcount_next = tcount + TCNT_W'(1);
      if (tcount_next == trig_ticks) begin
        tcount_next = '0;
        tout_next   = '0;
        phase_next  = PH_ECHO;
      end
    end else if (phase == PH_DONE) begin
      cur_idx_next = (cur_idx == IDX_W'(SENSOR_COUNT - 1)) ? '0 : cur_idx + IDX_W'(1);
      phase_next   = PH_TRIGGER;
    end

    for (int i = 0; i < ECHO_W; i++) begin
      if (32'(cur_idx_next) == i) level = echo_lat[i];
    end

    if (phase_next == PH_ECHO) begin
      if (level) seen_next = 1'b1;
      if (seen_next) begin
        if (ecount_next != '1) ecount_next = ecount_next + CNT_W'(1);
        if (!level) begin
          step_done   = 1'b1;
          step_cnt    = ecount_next;
          seen_next   = 1'b0;
          ecount_next = '0;
          phase_next  = PH_DONE;
        end
      end
    end
  end

  logic             pend_done;
  logic [IDX_W-1:0] pend_idx;
  logic [CNT_W-1:0] calc_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_idx <= '0;
      phase   <= PH_TRIGGER;
      tcount  <= '0;
      seen    <= 1'b0;
      ecount  <= '0;
      tout    <= '0;
    end else if (cmd.step) begin
      cur_idx <= cur_idx_next;
      phase   <= phase_next;
      tcount  <= tcount_next;
      seen    <= seen_next;
      ecount  <= ecount_next;
      tout    <= tout_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      pend_done <= step_done;
      pend_idx  <= cur_idx_next;
      calc_cnt  <= step_cnt;
    end
  end

  // interval = min(count * period, 65535); distance = interval * speed / 20000
  logic [P1_W-1:0]       p1;
  logic [INTERVAL_W-1:0] interval;
  logic [P2_W-1:0]       p2;
  logic [P3_W-1:0]       p3;
  logic [DIST_W-1:0]     dist_cm;

  assign interval = (p1 > P1_W'(INTERVAL_MAX)) ? INTERVAL_MAX : p1[INTERVAL_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.mul1) p1 <= P1_W'(calc_cnt) * P1_W'(period);
    if (cmd.mul2) p2 <= P2_W'(interval) * P2_W'(speed);
    if (cmd.mul3) p3 <= P3_W'(p2[P2_W-1:PRE_SHIFT]) * P3_W'(RECIP);
  end

  assign dist_cm = pend_done ? p3[RECIP_SHIFT +: DIST_W] : '0;

  logic [DIST_W-1:0] store [SENSOR_COUNT];
  logic              load;
  logic [DIST_W-1:0] qdist;

  assign load = cmd.finish && status.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SENSOR_COUNT; i++) store[i] <= '0;
    end else if (load && pend_done) begin
      store[pend_idx] <= dist_cm;
    end
  end

  // read after this tick's update
  always_comb begin
    qdist = '0;
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      if (32'(query_lat) == i) begin
        qdist = (pend_done && 32'(pend_idx) == i) ? dist_cm : store[i];
      end
    end
  end

  logic out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.trigger_levels   <= tout;
      result.active_sensor    <= ACT_W'(cur_idx);
      result.measure_done     <= pend_done;
      result.done_sensor      <= pend_done ? ACT_W'(pend_idx) : '0;
      result.done_distance    <= dist_cm;
      result.queried_distance <= qdist;
    end
  end

  assign result.valid    = out_valid;
  assign status.accepted = accepted;
  assign status.measure  = step_done;
  assign status.out_free = !out_valid || result.ready;

endmodule

// ===== rtl/ultrasonic_round_robin_ranger_top.sv =====
// ----------------------------------------------------------------------------
// ultrasonic_round_robin_ranger_top
// Round-robin trigger/echo ranger over four sensors, one tick per item.
// ----------------------------------------------------------------------------
// Flow: accept, step, then load the output register; a completing
//   measurement first goes through three registered multiplier stages
//   for the distance. The load waits while the output register is held;
//   the next item is taken while a result waits in the output register.
// Reset (rst, synchronous): sensor 0, trigger phase, counts and store
//   cleared, registers at trigger_ticks 2, tick_period_us 10, speed 340.
module ultrasonic_round_robin_ranger_top
  import urr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  urr_in_if.sink                tick,
  urr_out_if.source             result
);

  dp_cmd_t    cmd;
  dp_status_t status;

  urr_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  urr_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tick      (tick),
    .result    (result),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

// ===== rtl/urr_checker.sv =====
// ----------------------------------------------------------------------------
// urr_checker
// Port-level checks on the ranger's result stream.
// ----------------------------------------------------------------------------
module urr_checker
  import urr_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic [TRIG_W-1:0] trigger_levels,
  input logic [ACT_W-1:0]  active_sensor,
  input logic              measure_done,
  input logic [ACT_W-1:0]  done_sensor,
  input logic [DIST_W-1:0] done_distance
);

  // trigger is already low while an echo ends
  a_trig_low_on_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && measure_done |-> trigger_levels == '0)
    else $error("trigger high on completing item");

  a_done_is_active: assert property (@(posedge clk) disable iff (rst)
    out_valid && measure_done |-> done_sensor == active_sensor)
    else $error("done sensor differs from active sensor");

  a_idle_fields_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !measure_done |-> done_sensor == '0 && done_distance == '0)
    else $error("done fields nonzero without a measurement");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(done_distance) &&
      $stable(active_sensor))
    else $error("stalled result item changed");

endmodule

bind ultrasonic_round_robin_ranger_top urr_checker u_urr_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (result.valid),
  .out_ready      (result.ready),
  .trigger_levels (result.trigger_levels),
  .active_sensor  (result.active_sensor),
  .measure_done   (result.measure_done),
  .done_sensor    (result.done_sensor),
  .done_distance  (result.done_distance)
);

// ===== verif/tb_ultrasonic_round_robin_ranger_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ultrasonic_round_robin_ranger_top
// Drives tick items (echo levels plus a query) into the ranger. A local
// model tracks the trigger, echo and done phases for each sensor, the
// distance store and the registers, and predicts one result item per tick.
// Results are checked field by field, in order. The run covers directed
// echo cases, register settings at their extremes, a trigger count that
// wraps, a saturated interval, and random echo bursts under several idle
// and stall patterns.
// ----------------------------------------------------------------------------
module tb_ultrasonic_round_robin_ranger_top;
  import urr_pkg::*;

  localparam int CLK_HALF        = 5;
  localparam int LATENCY         = 6;
  localparam int CYCLE_LIMIT     = 500000;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 48;
  localparam int HOLD_CYCLES     = 300;
  localparam int LONG_ECHO_TICKS = 530;
  localparam int INTERVAL_CAP    = 65535;
  localparam int CM_DIVISOR      = 20000;
  localparam int PICK_RANDOM     = -1;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [ECHO_W-1:0]  echo_levels;
    logic [QUERY_W-1:0] query_sensor;
  } tick_item_t;

  typedef struct packed {
    logic [TRIG_W-1:0] trigger_levels;
    logic [ACT_W-1:0]  active_sensor;
    logic              measure_done;
    logic [ACT_W-1:0]  done_sensor;
    logic [DIST_W-1:0] done_distance;
    logic [DIST_W-1:0] queried_distance;
  } reading_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  urr_in_if  tick_ch ();
  urr_out_if result_ch ();

  ultrasonic_round_robin_ranger_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tick      (tick_ch),
    .result    (result_ch)
  );

  always #CLK_HALF clk = ~clk;

  // ranger model state
  logic [TCNT_W-1:0]   reg_trigger_ticks = RST_TRIGGER_TICKS;
  logic [PERIOD_W-1:0] reg_tick_period   = RST_TICK_PERIOD;
  logic [SPEED_W-1:0]  reg_sound_speed   = RST_SOUND_SPEED;
  logic [IDX_W-1:0]    srv_index  = '0;
  phase_t              srv_phase  = PH_TRIGGER;
  logic [TCNT_W-1:0]   trig_count = '0;
  logic                echo_armed = 1'b0;
  logic [CNT_W-1:0]    echo_ticks = '0;
  logic [TRIG_W-1:0]   trig_drive = '0;
  logic [DIST_W-1:0]   range_store [SENSOR_COUNT] = '{default: '0};

  tick_item_t tick_backlog [$];
  reading_t   expected_readings [$];

  int   fail_count     = 0;
  int   cycle_count    = 0;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  int   hold_left      = 0;
  logic hold_req       = 1'b0;
  logic hold_ack       = 1'b0;
  logic tick_taken     = 1'b0;

  function automatic logic [DIST_W-1:0] echo_to_cm(input logic [CNT_W-1:0] ticks);
    int unsigned interval;
    interval = ticks * reg_tick_period;
    if (interval > INTERVAL_CAP) interval = INTERVAL_CAP;
    return DIST_W'((interval * reg_sound_speed) / CM_DIVISOR);
  endfunction

  task automatic range_tick(input tick_item_t t, output reading_t r);
    logic level;
    r = '0;
    if (srv_phase == PH_TRIGGER) begin
      trig_drive = TRIG_W'(1) << srv_index;
      trig_count = trig_count + 1'b1;
      if (trig_count == reg_trigger_ticks) begin
        trig_count = '0;
        trig_drive = '0;
        srv_phase  = PH_ECHO;
      end
    end else if (srv_phase == PH_DONE) begin
      srv_index = (srv_index == IDX_W'(SENSOR_COUNT - 1)) ? '0 : srv_index + 1'b1;
      srv_phase = PH_TRIGGER;
    end
    level = t.echo_levels[srv_index];
    if (srv_phase == PH_ECHO) begin
      if (level) echo_armed = 1'b1;
      if (echo_armed) begin
        if (echo_ticks != '1) echo_ticks = echo_ticks + 1'b1;
        if (!level) begin
          r.measure_done           = 1'b1;
          r.done_sensor            = srv_index;
          r.done_distance          = echo_to_cm(echo_ticks);
          range_store[srv_index]   = r.done_distance;
          echo_armed               = 1'b0;
          echo_ticks               = '0;
          srv_phase                = PH_DONE;
        end
      end
    end
    r.trigger_levels   = trig_drive;
    r.active_sensor    = srv_index;
    r.queried_distance = range_store[t.query_sensor];
  endtask

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // tick driver
  always @(negedge clk) begin : drive_ticks
    tick_item_t item;
    if (!rst && (!tick_ch.valid || tick_taken)) begin
      if (tick_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        item = tick_backlog.pop_front();
        tick_ch.valid        <= 1'b1;
        tick_ch.echo_levels  <= item.echo_levels;
        tick_ch.query_sensor <= item.query_sensor;
      end else begin
        tick_ch.valid        <= 1'b0;
        tick_ch.echo_levels  <= ECHO_W'($urandom);
        tick_ch.query_sensor <= QUERY_W'($urandom);
      end
    end
  end

  // long receiver hold-off
  always @(negedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) result_ch.ready <= 1'b0;
    else result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // accept, predict, check
  always @(posedge clk) begin : check_results
    tick_item_t t;
    reading_t   want;
    tick_taken <= tick_ch.valid && tick_ch.ready;
    if (!rst) begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TRIGGER_TICKS: reg_trigger_ticks = cfg_data[TCNT_W-1:0];
          CFG_TICK_PERIOD:   reg_tick_period   = cfg_data[PERIOD_W-1:0];
          CFG_SOUND_SPEED:   reg_sound_speed   = cfg_data[SPEED_W-1:0];
          default: ;
        endcase
      end
      if (tick_ch.valid && tick_ch.ready) begin
        t.echo_levels  = tick_ch.echo_levels;
        t.query_sensor = tick_ch.query_sensor;
        range_tick(t, want);
        expected_readings.push_back(want);
      end
      if (result_ch.valid && result_ch.ready) begin
        if (expected_readings.size() == 0) begin
          $error("result item with no expected item");
          fail_count++;
        end else begin
          want = expected_readings.pop_front();
          check_field("trigger_levels", want.trigger_levels, result_ch.trigger_levels);
          check_field("active_sensor", want.active_sensor, result_ch.active_sensor);
          check_field("measure_done", want.measure_done, result_ch.measure_done);
          check_field("done_sensor", want.done_sensor, result_ch.done_sensor);
          check_field("done_distance", want.done_distance, result_ch.done_distance);
          check_field("queried_distance", want.queried_distance,
                      result_ch.queried_distance);
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  task automatic queue_tick(input logic [ECHO_W-1:0] echo);
    tick_item_t item;
    item.echo_levels  = echo;
    item.query_sensor = QUERY_W'($urandom_range(SENSOR_COUNT - 1));
    tick_backlog.push_back(item);
  endtask

  task automatic queue_directed(input logic [ECHO_W-1:0] echo,
                                input logic [QUERY_W-1:0] query);
    tick_item_t item;
    item.echo_levels  = echo;
    item.query_sensor = query;
    tick_backlog.push_back(item);
  endtask

  // quiet lead, echo pulse on a mask of sensors, quiet tail; sometimes noise
  task automatic queue_burst(inout int n);
    int lead, width, tail, noise;
    logic [ECHO_W-1:0] mask;
    lead  = $urandom_range(0, 20);
    width = ($urandom_range(9) == 0) ? $urandom_range(41, 160) : $urandom_range(1, 40);
    tail  = $urandom_range(1, 4);
    mask  = ($urandom_range(9) < 7) ? '1 : ECHO_W'($urandom);
    noise = ($urandom_range(6) == 0) ? $urandom_range(1, 10) : 0;
    repeat (lead) queue_tick(ECHO_W'($urandom) & ~mask);
    repeat (width) queue_tick(mask | (ECHO_W'($urandom) & ~mask));
    repeat (tail) queue_tick(ECHO_W'($urandom) & ~mask);
    repeat (noise) queue_tick(ECHO_W'($urandom));
    n += lead + width + tail + noise;
  endtask

  task automatic wait_drained();
    while (tick_backlog.size() != 0 || tick_ch.valid || expected_readings.size() != 0)
      @(posedge clk);
  endtask

  task automatic wait_idle();
    wait_drained();
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic load_registers(input int trig, input int period, input int speed);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TRIGGER_TICKS;
    cfg_data  <= CFG_DATA_W'(trig);
    @(negedge clk);
    cfg_index <= CFG_TICK_PERIOD;
    cfg_data  <= CFG_DATA_W'(period);
    @(negedge clk);
    cfg_index <= CFG_SOUND_SPEED;
    cfg_data  <= CFG_DATA_W'(speed);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SEND: begin send_idle_pct = 87; recv_stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 87; end
      default:   begin send_idle_pct = 14; recv_stall_pct = 14; end
    endcase
  endtask

  initial begin : stimulus
    int ph_trig [PHASES];
    int ph_period [PHASES];
    int ph_speed [PHASES];
    idle_mode_t ph_mode [PHASES];
    int trig, period, speed, queued;

    ph_trig   = '{2, 15, 1, 0, PICK_RANDOM, PICK_RANDOM, PICK_RANDOM, 3};
    ph_period = '{10, 1, 100, 127, 0, PICK_RANDOM, PICK_RANDOM, 100};
    ph_speed  = '{340, 1000, 1, 1023, PICK_RANDOM, 0, PICK_RANDOM, 1023};
    ph_mode   = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH,
                  IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH};

    cfg_we               = 1'b0;
    cfg_index            = '0;
    cfg_data             = '0;
    tick_ch.valid        = 1'b0;
    tick_ch.echo_levels  = '0;
    tick_ch.query_sensor = '0;
    result_ch.ready      = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // sensor 0 at reset settings: two trigger ticks, eight high, one low
    queue_directed(4'h0, 2'd0);
    queue_directed(4'h0, 2'd1);
    repeat (4) queue_directed(4'h1, 2'd2);
    repeat (4) queue_directed(4'hF, 2'd3);
    queue_directed(4'hE, 2'd0);
    queue_directed(4'h0, 2'd0);
    wait_idle();

    // one-tick trigger: echo already high on the tick the trigger ends
    load_registers(1, 127, 1023);
    queue_directed(4'h2, 2'd1);
    queue_directed(4'hD, 2'd1);
    queue_directed(4'hF, 2'd0);
    queue_directed(4'h0, 2'd2);
    queue_directed(4'h0, 2'd3);

    for (int p = 0; p < PHASES; p++) begin
      trig   = (ph_trig[p] == PICK_RANDOM) ? $urandom_range(1, 15) : ph_trig[p];
      period = (ph_period[p] == PICK_RANDOM) ? $urandom_range(1, 100) : ph_period[p];
      speed  = (ph_speed[p] == PICK_RANDOM) ? $urandom_range(1, 1000) : ph_speed[p];
      wait_drained();
      // stop partway into a long trigger pulse so the lower count has to wrap;
      // the running count never exceeds trigger_ticks - 1
      if (trig < int'(reg_trigger_ticks) - 1) begin
        while (!(srv_phase == PH_TRIGGER && trig_count > TCNT_W'(trig))) begin
          queue_tick(ECHO_W'($urandom));
          wait_drained();
        end
      end
      wait_idle();
      load_registers(trig, period, speed);
      set_idling(ph_mode[p]);
      queued = 0;
      while (queued < ITEMS_PER_PHASE / 2) queue_burst(queued);
      if (p == 0) hold_req = ~hold_req;
      wait_drained();
      while (queued < ITEMS_PER_PHASE) queue_burst(queued);
    end

    // echo long enough to saturate the interval
    wait_idle();
    load_registers(1, 127, 1023);
    set_idling(IDLE_NONE);
    repeat (5) queue_tick(4'h0);
    repeat (LONG_ECHO_TICKS) queue_tick(4'hF);
    repeat (3) queue_tick(4'h0);

    wait_drained();
    repeat (4 * LATENCY) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
